// ===== hw/rtl/sbrc_pkg.sv =====
// Shared types and constants for the sixteen-bit RISC core step block.
package sbrc_pkg;

  localparam int unsigned XLEN = 16;
  localparam int unsigned ALEN = 13;
  localparam int unsigned RIDX = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_OR  = 4'd2;
  localparam logic [3:0] FN_AND = 4'd3;
  localparam logic [3:0] FN_SLT = 4'd4;
  localparam logic [3:0] FN_JR  = 4'd8;

  localparam logic [RIDX-1:0] LINK_REG = 3'd7;

  typedef enum logic [2:0] {
    OPC_ALU  = 3'd0,
    OPC_ADDI = 3'd1,
    OPC_J    = 3'd2,
    OPC_JAL  = 3'd3,
    OPC_LW   = 3'd4,
    OPC_SW   = 3'd5,
    OPC_JEQ  = 3'd6,
    OPC_SLTI = 3'd7
  } opc_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_EXEC   = 2'd2,
    ST_LWB    = 2'd3
  } state_e;

  typedef struct packed {
    logic            op;
    logic [ALEN-1:0] load_address;
    logic [XLEN-1:0] load_data;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            halted;
    logic            reg_written;
    logic [RIDX-1:0] reg_index;
    logic [XLEN-1:0] reg_value;
    logic            mem_written;
    logic [ALEN-1:0] mem_address;
    logic [XLEN-1:0] mem_value;
  } rsp_t;

  // Decoded and evaluated instruction, passed from the execute unit.
  typedef struct packed {
    logic [XLEN-1:0] npc;
    logic            reg_we;
    logic [RIDX-1:0] dst;
    logic [XLEN-1:0] val;
    logic            is_lw;
    logic            is_sw;
    logic [ALEN-1:0] daddr;
    logic [XLEN-1:0] sdata;
  } exec_t;

endpackage

// ===== hw/rtl/sixteen_bit_risc_core_step.sv =====
// Top level of the sixteen-bit RISC core step block: request buffer, sequencer, result register.
// A load, or a step on a halted core, is answered from the idle state; an executed step runs
//   fetch read, register read and execute, and lw adds a second memory read before write-back.
// The buffer can take the next request while the sequencer still works on the current one.
// Reset: memory clears word by word with in_ready_o low; regs, pc and halt zero at once.
module sixteen_bit_risc_core_step #(
  parameter int unsigned MEM_WORDS = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbrc_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sbrc_pkg::rsp_t   out_rsp_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // Request buffer: lets a new request in while the sequencer is busy with the last one.
  logic            ibuf_vld_q;
  logic            ibuf_vld_d;
  sbrc_pkg::req_t  ibuf_req_q;

  // Sequencer state and architectural state that lives in flip-flops.
  sbrc_pkg::state_e          state_q;
  sbrc_pkg::state_e          state_d;
  logic [sbrc_pkg::XLEN-1:0] pc_q;
  logic [sbrc_pkg::XLEN-1:0] pc_d;
  logic                      halt_q;
  logic                      halt_d;
  logic [sbrc_pkg::XLEN-1:0] ir_q;
  logic [sbrc_pkg::XLEN-1:0] ir_d;

  // Result register.
  logic            out_vld_q;
  logic            out_vld_d;
  sbrc_pkg::rsp_t  out_rsp_q;
  sbrc_pkg::rsp_t  out_rsp_d;
  logic            out_load;
  logic            out_free;

  logic            consume;

  // Memory port controls.
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [sbrc_pkg::XLEN-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [sbrc_pkg::XLEN-1:0] mem_rdata;
  logic                      mem_busy;

  // Register file controls.
  logic                      rf_we;
  logic [sbrc_pkg::RIDX-1:0] rf_waddr;
  logic [sbrc_pkg::XLEN-1:0] rf_wdata;
  logic                      rf_re;
  logic [sbrc_pkg::XLEN-1:0] va;
  logic [sbrc_pkg::XLEN-1:0] vb;

  sbrc_pkg::exec_t           ex;

  sbrc_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // The register read addresses come straight from the fetched word, which is the
  // registered output of the memory during the decode cycle.
  sbrc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .re_i      (rf_re),
    .raddr_a_i (mem_rdata[12:10]),
    .raddr_b_i (mem_rdata[9:7]),
    .rdata_a_o (va),
    .rdata_b_o (vb)
  );

  sbrc_exec u_exec (
    .ir_i (ir_q),
    .pc_i (pc_q),
    .va_i (va),
    .vb_i (vb),
    .ex_o (ex)
  );

  // The buffer takes a request only when empty and never during the clearing pass.
  assign in_ready_o = !ibuf_vld_q && !mem_busy;

  // A request starts only when the result register can take its result by the time it
  // finishes; an executing step keeps the result register empty until it completes.
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    ir_d      = ir_q;
    consume   = 1'b0;
    out_load  = 1'b0;
    out_rsp_d = '0;
    mem_we    = 1'b0;
    mem_waddr = ibuf_req_q.load_address[AW-1:0];
    mem_wdata = ibuf_req_q.load_data;
    mem_re    = 1'b0;
    mem_raddr = pc_q[AW-1:0];
    rf_we     = 1'b0;
    rf_waddr  = ex.dst;
    rf_wdata  = ex.val;
    rf_re     = 1'b0;

    unique case (state_q)
      sbrc_pkg::ST_IDLE: begin
        if (ibuf_vld_q && out_free && !mem_busy) begin
          consume = 1'b1;
          if (ibuf_req_q.op == sbrc_pkg::OP_LOAD) begin
            // A load writes memory even on a halted core; pc and halt are reported as is.
            mem_we                = 1'b1;
            out_load              = 1'b1;
            out_rsp_d.next_pc     = pc_q;
            out_rsp_d.halted      = halt_q;
            out_rsp_d.mem_written = 1'b1;
            out_rsp_d.mem_address = ibuf_req_q.load_address;
            out_rsp_d.mem_value   = ibuf_req_q.load_data;
          end else if (halt_q) begin
            out_load          = 1'b1;
            out_rsp_d.next_pc = pc_q;
            out_rsp_d.halted  = 1'b1;
          end else begin
            // Fetch the instruction at pc modulo the memory size.
            mem_re  = 1'b1;
            state_d = sbrc_pkg::ST_DECODE;
          end
        end
      end
      sbrc_pkg::ST_DECODE: begin
        ir_d    = mem_rdata;
        rf_re   = 1'b1;
        state_d = sbrc_pkg::ST_EXEC;
      end
      sbrc_pkg::ST_EXEC: begin
        if (ex.is_lw) begin
          mem_re    = 1'b1;
          mem_raddr = ex.daddr[AW-1:0];
          state_d   = sbrc_pkg::ST_LWB;
        end else begin
          mem_we    = ex.is_sw;
          mem_waddr = ex.daddr[AW-1:0];
          mem_wdata = ex.sdata;
          rf_we     = ex.reg_we;
          pc_d      = ex.npc;
          halt_d    = halt_q || (ex.npc == pc_q);
          out_load  = 1'b1;
          out_rsp_d.next_pc     = ex.npc;
          out_rsp_d.halted      = halt_d;
          out_rsp_d.reg_written = ex.reg_we;
          out_rsp_d.reg_index   = ex.reg_we ? ex.dst : '0;
          out_rsp_d.reg_value   = ex.reg_we ? ex.val : '0;
          out_rsp_d.mem_written = ex.is_sw;
          out_rsp_d.mem_address = ex.is_sw ? ex.daddr : '0;
          out_rsp_d.mem_value   = ex.is_sw ? ex.sdata : '0;
          state_d               = sbrc_pkg::ST_IDLE;
        end
      end
      sbrc_pkg::ST_LWB: begin
        // The loaded word is in the memory read register now; the execute unit still
        // holds the decoded instruction, so its destination and next pc stay valid.
        rf_we     = ex.reg_we;
        rf_wdata  = mem_rdata;
        pc_d      = ex.npc;
        halt_d    = halt_q || (ex.npc == pc_q);
        out_load  = 1'b1;
        out_rsp_d.next_pc     = ex.npc;
        out_rsp_d.halted      = halt_d;
        out_rsp_d.reg_written = ex.reg_we;
        out_rsp_d.reg_index   = ex.reg_we ? ex.dst : '0;
        out_rsp_d.reg_value   = ex.reg_we ? mem_rdata : '0;
        state_d               = sbrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ibuf_vld_d = ibuf_vld_q;
    if (consume) begin
      ibuf_vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      ibuf_vld_d = 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sbrc_pkg::ST_IDLE;
      pc_q       <= '0;
      halt_q     <= 1'b0;
      ir_q       <= '0;
      ibuf_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      halt_q     <= halt_d;
      ir_q       <= ir_d;
      ibuf_vld_q <= ibuf_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ibuf_req_q <= in_req_i;
    end
    if (out_load) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // No request enters while main memory is still being cleared.
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !in_ready_o
  ) else $error("request accepted during the memory clearing pass");

  // An executing step keeps the result register empty until it completes.
  a_out_empty_in_flight : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q != sbrc_pkg::ST_IDLE) |-> !out_vld_q
  ) else $error("result register occupied while a step is executing");

  // Once halted, the core stays halted and the pc no longer moves.
  a_halt_sticky : assert property (
    @(posedge clk_i) disable iff (!rst_ni) halt_q |=> (halt_q && $stable(pc_q))
  ) else $error("halted core changed pc or left the halted state");

  // Register zero is never written.
  a_no_r0_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni) rf_we |-> (rf_waddr != '0)
  ) else $error("write to register zero");

  // A data access on the memory port happens only for lw or sw in the execute cycle.
  a_mem_access_owner : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (mem_we && (state_q != sbrc_pkg::ST_IDLE)) |-> ((state_q == sbrc_pkg::ST_EXEC) && ex.is_sw)
  ) else $error("memory write outside a load request or sw");

endmodule

// ===== hw/rtl/sbrc_mem.sv =====
// Main memory: one write port, one registered read port, and a clearing pass after reset.
module sbrc_mem #(
  parameter int unsigned MEM_WORDS = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [$clog2(MEM_WORDS)-1:0] waddr_i,
  input  logic [sbrc_pkg::XLEN-1:0]    wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(MEM_WORDS)-1:0] raddr_i,
  output logic [sbrc_pkg::XLEN-1:0]    rdata_o,
  output logic                         busy_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [sbrc_pkg::XLEN-1:0] mem_q [MEM_WORDS];
  logic [AW:0]               clr_cnt_q;
  logic [sbrc_pkg::XLEN-1:0] rdata_q;

  assign busy_o  = (clr_cnt_q != (AW+1)'(MEM_WORDS));
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (busy_o) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // The clearing pass owns the write port until every word is zero.
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem_q[clr_cnt_q[AW-1:0]] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/sbrc_regfile.sv =====
// Register file: eight words with two registered read ports and per-entry valid bits.
module sbrc_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [sbrc_pkg::RIDX-1:0] waddr_i,
  input  logic [sbrc_pkg::XLEN-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [sbrc_pkg::RIDX-1:0] raddr_a_i,
  input  logic [sbrc_pkg::RIDX-1:0] raddr_b_i,
  output logic [sbrc_pkg::XLEN-1:0] rdata_a_o,
  output logic [sbrc_pkg::XLEN-1:0] rdata_b_o
);

  localparam int unsigned NREG = 2 ** sbrc_pkg::RIDX;

  logic [sbrc_pkg::XLEN-1:0] rf_q [NREG];
  logic [NREG-1:0]           vld_q;
  logic [sbrc_pkg::XLEN-1:0] rd_a_q;
  logic [sbrc_pkg::XLEN-1:0] rd_b_q;
  logic                      vld_a_q;
  logic                      vld_b_q;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_a_q <= vld_q[raddr_a_i];
        vld_b_q <= vld_q[raddr_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rf_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= rf_q[raddr_a_i];
      rd_b_q <= rf_q[raddr_b_i];
    end
  end

  assign rdata_a_o = vld_a_q ? rd_a_q : '0;
  assign rdata_b_o = vld_b_q ? rd_b_q : '0;

endmodule

// ===== hw/rtl/sbrc_exec.sv =====
// Execute unit: decodes one instruction and computes next pc, write-back and data address.
module sbrc_exec (
  input  logic [sbrc_pkg::XLEN-1:0] ir_i,
  input  logic [sbrc_pkg::XLEN-1:0] pc_i,
  input  logic [sbrc_pkg::XLEN-1:0] va_i,
  input  logic [sbrc_pkg::XLEN-1:0] vb_i,
  output sbrc_pkg::exec_t           ex_o
);

  sbrc_pkg::opc_e            opc;
  logic [sbrc_pkg::RIDX-1:0] rb;
  logic [sbrc_pkg::RIDX-1:0] rc;
  logic [3:0]                fn;
  logic [sbrc_pkg::XLEN-1:0] imm7;
  logic [sbrc_pkg::XLEN-1:0] imm13;
  logic [sbrc_pkg::XLEN-1:0] pc1;
  logic [sbrc_pkg::XLEN-1:0] asum;
  logic                      wr;
  logic [sbrc_pkg::RIDX-1:0] dst;
  logic [sbrc_pkg::XLEN-1:0] val;
  logic [sbrc_pkg::XLEN-1:0] npc;

  assign opc   = sbrc_pkg::opc_e'(ir_i[15:13]);
  assign rb    = ir_i[9:7];
  assign rc    = ir_i[6:4];
  assign fn    = ir_i[3:0];
  assign imm7  = {{(sbrc_pkg::XLEN-7){ir_i[6]}}, ir_i[6:0]};
  assign imm13 = {{(sbrc_pkg::XLEN-sbrc_pkg::ALEN){1'b0}}, ir_i[sbrc_pkg::ALEN-1:0]};
  assign pc1   = pc_i + 1'b1;
  assign asum  = va_i + imm7;

  always_comb begin
    wr  = 1'b0;
    dst = '0;
    val = '0;
    npc = pc1;
    unique case (opc)
      sbrc_pkg::OPC_ALU: begin
        priority case (fn)
          sbrc_pkg::FN_ADD: begin wr = 1'b1; dst = rc; val = va_i + vb_i; end
          sbrc_pkg::FN_SUB: begin wr = 1'b1; dst = rc; val = va_i - vb_i; end
          sbrc_pkg::FN_OR:  begin wr = 1'b1; dst = rc; val = va_i | vb_i; end
          sbrc_pkg::FN_AND: begin wr = 1'b1; dst = rc; val = va_i & vb_i; end
          sbrc_pkg::FN_SLT: begin
            wr  = 1'b1;
            dst = rc;
            val = {{(sbrc_pkg::XLEN-1){1'b0}}, (va_i < vb_i)};
          end
          sbrc_pkg::FN_JR:  npc = va_i;
          default: ;  // Undefined function codes only advance the pc.
        endcase
      end
      sbrc_pkg::OPC_ADDI: begin wr = 1'b1; dst = rb; val = asum; end
      sbrc_pkg::OPC_J:    npc = imm13;
      sbrc_pkg::OPC_JAL:  begin wr = 1'b1; dst = sbrc_pkg::LINK_REG; val = pc1; npc = imm13; end
      sbrc_pkg::OPC_LW:   begin wr = 1'b1; dst = rb; end
      sbrc_pkg::OPC_SW:   ;
      sbrc_pkg::OPC_JEQ:  begin
        if (va_i == vb_i) begin
          npc = pc1 + imm7;
        end
      end
      sbrc_pkg::OPC_SLTI: begin
        wr  = 1'b1;
        dst = rb;
        val = {{(sbrc_pkg::XLEN-1){1'b0}}, (va_i < imm7)};
      end
    endcase
  end

  // Writes aimed at register zero are dropped here, once for all opcodes.
  assign ex_o.npc    = npc;
  assign ex_o.reg_we = wr && (dst != '0);
  assign ex_o.dst    = dst;
  assign ex_o.val    = val;
  assign ex_o.is_lw  = (opc == sbrc_pkg::OPC_LW);
  assign ex_o.is_sw  = (opc == sbrc_pkg::OPC_SW);
  assign ex_o.daddr  = asum[sbrc_pkg::ALEN-1:0];
  assign ex_o.sdata  = vb_i;

endmodule

// ===== verif/sixteen_bit_risc_core_step_tb.sv =====
// Self-checking testbench for the sixteen-bit RISC core step block.
module sixteen_bit_risc_core_step_tb;

  localparam int unsigned XLEN           = sbrc_pkg::XLEN;
  localparam int unsigned ALEN           = sbrc_pkg::ALEN;
  localparam int unsigned RIDX           = sbrc_pkg::RIDX;
  localparam int unsigned MEM_WORDS      = 8192;
  // The longest quiet stretch in a correct run is the memory clearing pass after reset;
  // the back-pressure hold-off is far shorter.
  localparam int unsigned WATCHDOG_LIMIT = 4 * MEM_WORDS;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_PRINTED    = 200;
  // A function code under the ALU opcode that the core treats as a no-op.
  localparam logic [3:0]  FN_UNDEF       = 4'd5;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic           in_valid  = 1'b0;
  logic           in_ready_o;
  sbrc_pkg::req_t in_req    = '0;
  logic           out_valid_o;
  logic           out_ready = 1'b0;
  sbrc_pkg::rsp_t out_rsp_o;

  sixteen_bit_risc_core_step #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk = ~clk;

  // Architectural state of the core as the testbench believes it to be. It is advanced
  // once per accepted request, so it always reflects every request sent so far.
  logic [XLEN-1:0] core_regs [8];
  logic [XLEN-1:0] core_mem  [MEM_WORDS];
  logic [XLEN-1:0] core_pc;
  logic            core_halted;

  // Results the core owes us, oldest first.
  sbrc_pkg::rsp_t expected_rsp_q [$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  int unsigned items_sent    = 0;
  int unsigned loads_sent    = 0;
  int unsigned steps_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned errors        = 0;

  // Executes one request on the testbench copy of the core and returns the result it
  // should produce. With commit low the state is left untouched, which lets the stimulus
  // look one instruction ahead.
  function automatic sbrc_pkg::rsp_t core_step(input sbrc_pkg::req_t r, input bit commit);
    sbrc_pkg::rsp_t  res;
    logic [XLEN-1:0] ins, va, vb, imm7, npc, val, pc, ea;
    logic [RIDX-1:0] dst;
    logic            wr, halt_n;
    sbrc_pkg::opc_e  opc;
    res    = '0;
    pc     = core_pc;
    halt_n = core_halted;
    if (r.op == sbrc_pkg::OP_LOAD) begin
      // Loads always land in memory, halted or not.
      if (commit) core_mem[r.load_address] = r.load_data;
      res.mem_written = 1'b1;
      res.mem_address = r.load_address;
      res.mem_value   = r.load_data;
    end else if (!core_halted) begin
      ins  = core_mem[pc[ALEN-1:0]];
      opc  = sbrc_pkg::opc_e'(ins[15:13]);
      va   = core_regs[ins[12:10]];
      vb   = core_regs[ins[9:7]];
      imm7 = {{9{ins[6]}}, ins[6:0]};
      ea   = va + imm7;
      npc  = pc + 16'd1;
      wr   = 1'b0;
      dst  = ins[9:7];
      val  = '0;
      case (opc)
        sbrc_pkg::OPC_ALU: begin
          dst = ins[6:4];
          case (ins[3:0])
            sbrc_pkg::FN_ADD: begin wr = 1'b1; val = va + vb; end
            sbrc_pkg::FN_SUB: begin wr = 1'b1; val = va - vb; end
            sbrc_pkg::FN_OR:  begin wr = 1'b1; val = va | vb; end
            sbrc_pkg::FN_AND: begin wr = 1'b1; val = va & vb; end
            sbrc_pkg::FN_SLT: begin wr = 1'b1; val = (va < vb) ? 16'd1 : 16'd0; end
            sbrc_pkg::FN_JR:  npc = va;
            default: ;
          endcase
        end
        sbrc_pkg::OPC_ADDI: begin wr = 1'b1; val = ea; end
        sbrc_pkg::OPC_J:    npc = {3'b000, ins[ALEN-1:0]};
        sbrc_pkg::OPC_JAL: begin
          wr  = 1'b1;
          dst = sbrc_pkg::LINK_REG;
          val = pc + 16'd1;
          npc = {3'b000, ins[ALEN-1:0]};
        end
        sbrc_pkg::OPC_LW: begin wr = 1'b1; val = core_mem[ea[ALEN-1:0]]; end
        sbrc_pkg::OPC_SW: begin
          if (commit) core_mem[ea[ALEN-1:0]] = vb;
          res.mem_written = 1'b1;
          res.mem_address = ea[ALEN-1:0];
          res.mem_value   = vb;
        end
        sbrc_pkg::OPC_JEQ:  if (va == vb) npc = pc + 16'd1 + imm7;
        sbrc_pkg::OPC_SLTI: begin wr = 1'b1; val = (va < imm7) ? 16'd1 : 16'd0; end
        default: ;
      endcase
      // Register zero is hard-wired; the write vanishes but pc still moves on.
      if (wr && dst != '0) begin
        if (commit) core_regs[dst] = val;
        res.reg_written = 1'b1;
        res.reg_index   = dst;
        res.reg_value   = val;
      end
      if (npc == pc) halt_n = 1'b1;
      pc = npc;
    end
    res.next_pc = pc;
    res.halted  = halt_n;
    if (commit) begin
      core_pc     = pc;
      core_halted = halt_n;
    end
    return res;
  endfunction

  function automatic logic [XLEN-1:0] enc_alu(input logic [2:0] ra, rb, rc,
                                              input logic [3:0] fn);
    return {sbrc_pkg::OPC_ALU, ra, rb, rc, fn};
  endfunction

  function automatic logic [XLEN-1:0] enc_imm(input sbrc_pkg::opc_e opc,
                                              input logic [2:0] ra, rb,
                                              input logic [6:0] imm);
    return {opc, ra, rb, imm};
  endfunction

  function automatic logic [XLEN-1:0] enc_jmp(input sbrc_pkg::opc_e opc,
                                              input logic [ALEN-1:0] tgt);
    return {opc, tgt};
  endfunction

  // A random instruction for a program placed at base. Jumps mostly stay inside the
  // program and branches are short, so that the program actually runs.
  function automatic logic [XLEN-1:0] rand_insn(input int unsigned base, len);
    sbrc_pkg::opc_e  opc;
    logic [3:0]      fn;
    logic [ALEN-1:0] tgt;
    int unsigned     roll;
    opc  = sbrc_pkg::opc_e'($urandom_range(7));
    tgt  = ALEN'(base + $urandom_range(len - 1));
    roll = $urandom_range(9);
    case (opc)
      sbrc_pkg::OPC_ALU: begin
        if (roll < 7)      fn = 4'($urandom_range(sbrc_pkg::FN_SLT, sbrc_pkg::FN_ADD));
        else if (roll < 9) fn = sbrc_pkg::FN_JR;
        else               fn = 4'($urandom);
        return {sbrc_pkg::OPC_ALU, 9'($urandom), fn};
      end
      sbrc_pkg::OPC_J, sbrc_pkg::OPC_JAL: begin
        return (roll < 7) ? {opc, tgt} : {opc, 13'($urandom)};
      end
      sbrc_pkg::OPC_JEQ: begin
        if (roll < 8) return {opc, 6'($urandom), 7'($urandom_range(6)) - 7'd3};
        return {opc, 13'($urandom)};
      end
      default: return {opc, 13'($urandom)};
    endcase
  endfunction

  function automatic sbrc_pkg::req_t mk_load(input logic [ALEN-1:0] addr,
                                             input logic [XLEN-1:0] data);
    sbrc_pkg::req_t r;
    r.op           = sbrc_pkg::OP_LOAD;
    r.load_address = addr;
    r.load_data    = data;
    return r;
  endfunction

  // Step requests carry random junk in the load fields, which the core must ignore.
  function automatic sbrc_pkg::req_t mk_step();
    sbrc_pkg::req_t r;
    r.op           = sbrc_pkg::OP_STEP;
    r.load_address = ALEN'($urandom);
    r.load_data    = XLEN'($urandom);
    return r;
  endfunction

  // Offers one request and returns once it has been accepted. Valid is only lowered for
  // an idle cycle, so back-to-back requests keep it high across the boundary.
  task automatic send_req(input sbrc_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    expected_rsp_q.push_back(core_step(r, 1'b1));
    items_sent++;
    if (r.op == sbrc_pkg::OP_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // Sends a step, but first replaces the instruction at pc with a plain ALU operation if
  // executing it would halt the core. Halting is permanent, so it is saved for the end.
  task automatic step_guarded(input sbrc_pkg::req_t r);
    sbrc_pkg::rsp_t peek;
    peek = core_step(r, 1'b0);
    if (peek.halted && !core_halted)
      send_req(mk_load(core_pc[ALEN-1:0],
                       enc_alu(3'($urandom), 3'($urandom), 3'($urandom),
                               4'($urandom_range(sbrc_pkg::FN_SLT, sbrc_pkg::FN_ADD)))));
    send_req(r);
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string fname, input logic [XLEN-1:0] got, want,
                             input int unsigned idx);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h", idx, fname, got, want));
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every accepted result is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    sbrc_pkg::rsp_t want, got;
    if (rst_n && out_valid_o && out_ready) begin
      got = out_rsp_o;
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("next_pc", got.next_pc, want.next_pc, results_seen);
        check_field("halted", XLEN'(got.halted), XLEN'(want.halted), results_seen);
        check_field("reg_written", XLEN'(got.reg_written), XLEN'(want.reg_written),
                    results_seen);
        check_field("reg_index", XLEN'(got.reg_index), XLEN'(want.reg_index), results_seen);
        check_field("reg_value", got.reg_value, want.reg_value, results_seen);
        check_field("mem_written", XLEN'(got.mem_written), XLEN'(want.mem_written),
                    results_seen);
        check_field("mem_address", XLEN'(got.mem_address), XLEN'(want.mem_address),
                    results_seen);
        check_field("mem_value", got.mem_value, want.mem_value, results_seen);
      end
      results_seen++;
    end
  end

  // Watchdog: the run is stuck if no request and no result moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // A hand-written program that touches every operation, including the write to
  // register zero, the undefined function code, wrapping data addresses and each jump.
  task automatic test_directed();
    tx_idle_pct = 17;
    rx_idle_pct = 78;
    send_req(mk_load(13'd0,  enc_imm(sbrc_pkg::OPC_ADDI, 3'd0, 3'd1, 7'h7f)));  // r1 = -1
    send_req(mk_load(13'd1,  enc_imm(sbrc_pkg::OPC_ADDI, 3'd0, 3'd2, 7'h3f)));  // r2 = 63
    send_req(mk_load(13'd2,  enc_alu(3'd1, 3'd2, 3'd3, sbrc_pkg::FN_ADD)));
    send_req(mk_load(13'd3,  enc_alu(3'd2, 3'd1, 3'd4, sbrc_pkg::FN_SUB)));
    send_req(mk_load(13'd4,  enc_alu(3'd1, 3'd2, 3'd5, sbrc_pkg::FN_OR)));
    send_req(mk_load(13'd5,  enc_alu(3'd1, 3'd2, 3'd6, sbrc_pkg::FN_AND)));
    send_req(mk_load(13'd6,  enc_alu(3'd2, 3'd1, 3'd3, sbrc_pkg::FN_SLT)));
    send_req(mk_load(13'd7,  enc_alu(3'd1, 3'd2, 3'd0, sbrc_pkg::FN_ADD)));  // dropped write
    send_req(mk_load(13'd8,  enc_imm(sbrc_pkg::OPC_SLTI, 3'd2, 3'd0, 7'h40)));  // dropped
    send_req(mk_load(13'd9,  enc_alu(3'd1, 3'd2, 3'd3, FN_UNDEF)));
    // Both data accesses compute 0xfffe, which wraps to the top of memory.
    send_req(mk_load(13'd10, enc_imm(sbrc_pkg::OPC_SW, 3'd1, 3'd1, 7'h7f)));
    send_req(mk_load(13'd11, enc_imm(sbrc_pkg::OPC_LW, 3'd1, 3'd4, 7'h7f)));
    send_req(mk_load(13'd12, enc_imm(sbrc_pkg::OPC_JEQ, 3'd0, 3'd0, 7'd2)));  // taken, to 15
    send_req(mk_load(13'd15, enc_jmp(sbrc_pkg::OPC_JAL, 13'd20)));
    send_req(mk_load(13'd20, enc_jmp(sbrc_pkg::OPC_J, 13'd25)));
    send_req(mk_load(13'd25, enc_alu(3'd7, 3'd0, 3'd0, sbrc_pkg::FN_JR)));  // back to 16
    repeat (17) send_req(mk_step());
  endtask

  // Mostly short random programs, each loaded at a fresh spot and entered by a jump planted
  // at the current pc. Some programs are never entered, and some bursts are pure noise.
  task automatic test_random_phase(input int unsigned tx_pct, rx_pct, n_items);
    int unsigned stop_at, len, base, roll;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        len = $urandom_range(16, 4);
        do base = $urandom_range(MEM_WORDS - 1 - len);
        while (core_pc[ALEN-1:0] >= base && core_pc[ALEN-1:0] <= base + len);
        for (int i = 0; i < len; i++)
          send_req(mk_load(ALEN'(base + i), rand_insn(base, len)));
        if (roll < 75)
          send_req(mk_load(core_pc[ALEN-1:0], enc_jmp(sbrc_pkg::OPC_J, ALEN'(base))));
        repeat (2 * len) step_guarded(mk_step());
      end else begin
        repeat ($urandom_range(12, 4)) begin
          if ($urandom_range(1) == 0) send_req(mk_load(ALEN'($urandom), XLEN'($urandom)));
          else step_guarded(mk_step());
        end
      end
    end
  endtask

  // The receiver stops taking results for a long stretch while steps keep coming, so the
  // core's buffers fill and it has to push back on its input.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = HOLD_CYCLES;
    repeat (30) step_guarded(mk_step());
  endtask

  // Halting comes last because nothing but reset clears it. A jump-and-link to itself
  // halts the core while still writing the link register; afterwards steps do nothing
  // and loads still land in memory.
  task automatic test_halt();
    logic [ALEN-1:0] tgt;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tgt = core_pc[ALEN-1:0] + 13'd100;
    send_req(mk_load(core_pc[ALEN-1:0], enc_jmp(sbrc_pkg::OPC_J, tgt)));
    send_req(mk_load(tgt, enc_jmp(sbrc_pkg::OPC_JAL, tgt)));
    send_req(mk_step());
    send_req(mk_step());
    repeat (3) send_req(mk_step());
    send_req(mk_load(13'd0, 16'h0000));
    send_req(mk_load(13'h1fff, 16'hffff));
    send_req(mk_load(tgt, 16'h0000));
    repeat (3) send_req(mk_step());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) core_regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) core_mem[i] = '0;
    core_pc     = '0;
    core_halted = 1'b0;

    // Single reset at the start. The core then clears its memory before taking requests;
    // the first send simply waits for in_ready.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(17, 78, 400);
    test_random_phase(78, 17, 400);
    test_random_phase(0, 0, 400);
    test_backpressure();
    test_halt();

    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests (%0d loads, %0d steps), %0d results checked",
             items_sent, loads_sent, steps_sent, results_seen);
    $display("summary: directed ops, random programs under three stall mixes, %s",
             "a long output hold-off, and a halted core taking steps and loads");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
